// File: design/http_chunked_body_decoder_top_assert.svh
// Assertion helpers for the chunked body decoder.
// Each macro expects clk and rst_n in scope.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define HCBD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcbd assertion failed");

// Next-cycle implication.
`define HCBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcbd assertion failed");

`endif

// File: design/hcbd_pkg.sv
package hcbd_pkg;

    // Input commands
    localparam logic [1:0] CMD_DATA    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_CLOSE   = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one ASCII hex digit; ok is low for anything else.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            d.value = 4'(c - 8'h30);
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            d.value = 4'(c - 8'h57);
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            d.value = 4'(c - 8'h37);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

// File: design/http_chunked_body_decoder_top.sv
// Channel  | Signals                              | Direction | Word
// ---------+--------------------------------------+-----------+---------------------------
// item     | item_valid, item_stall, cmd,         | in        | one body byte or a command
//          | data_byte                            |           |
// result   | result_valid, result_stall, kind,    | out       | payload byte, done or error
//          | payload_byte                         |           |
//
// One word per cycle sustained while the result is not stalled.
// A word waits in the input register, then the phase logic updates state and loads the
// result register at the same edge; result_valid rises when that edge loads a result.
// rst_n clears the phase, counters and both valid flags asynchronously.
// A stalled result holds a waiting input word; item_stall then rises in the same cycle.
module http_chunked_body_decoder_top
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] data_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] kind,
    output logic [7:0] payload_byte
);

    typedef enum logic [2:0] {
        PH_FIRST,   // expect first size digit
        PH_SIZE,    // more size digits or CR
        PH_LF,      // LF after the size line
        PH_DATA,    // payload bytes
        PH_TCR,     // CR after the payload
        PH_TLF,     // LF after the payload
        PH_DONE,
        PH_ERR
    } phase_t;

    // Input register
    logic                 in_valid_reg;
    logic [1:0]           cmd_reg;
    logic [7:0]           byte_reg;

    // Decoder state
    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] size_accum_reg, size_accum_next;
    logic [SIZE_BITS-1:0] bytes_left_reg, bytes_left_next;

    // Result register
    logic                 out_valid_reg;
    logic [1:0]           kind_reg;
    logic [7:0]           payload_reg;

    logic                 advance;
    logic                 res_valid;
    logic [1:0]           res_kind;
    logic [7:0]           res_byte;
    hex_digit_t           digit;
    logic                 size_full;
    logic [SIZE_BITS-1:0] size_shifted;
    logic [SIZE_BITS-1:0] bytes_dec;

    // Move the input word forward whenever the result register is free or drains.
    assign advance    = !out_valid_reg || !result_stall;
    assign item_stall = in_valid_reg && !advance;

    assign digit        = hex_decode(byte_reg);
    // Another digit would push the size past SIZE_BITS when the top nibble is in use.
    assign size_full    = (size_accum_reg[SIZE_BITS-1 -: 4] != 4'd0);
    assign size_shifted = {size_accum_reg[SIZE_BITS-5:0], digit.value};
    assign bytes_dec    = bytes_left_reg - SIZE_BITS'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        size_accum_next = size_accum_reg;
        bytes_left_next = bytes_left_reg;
        res_valid       = 1'b0;
        res_kind        = KIND_BYTE;
        res_byte        = 8'd0;

        case (cmd_reg)
            CMD_RESTART:
            begin
                phase_next      = PH_FIRST;
                size_accum_next = '0;
                bytes_left_next = '0;
            end
            CMD_CLOSE:
            begin
                if (phase_reg == PH_FIRST)
                begin
                    // Closing between chunks ends the body cleanly.
                    phase_next = PH_DONE;
                    res_valid  = 1'b1;
                    res_kind   = KIND_DONE;
                end
                else if (phase_reg != PH_DONE && phase_reg != PH_ERR)
                begin
                    phase_next = PH_ERR;
                    res_valid  = 1'b1;
                    res_kind   = KIND_ERR;
                end
            end
            CMD_DATA:
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        if (digit.ok)
                        begin
                            size_accum_next = SIZE_BITS'(digit.value);
                            phase_next      = PH_SIZE;
                        end
                        else
                        begin
                            phase_next = PH_ERR;
                            res_valid  = 1'b1;
                            res_kind   = KIND_ERR;
                        end
                    end
                    PH_SIZE:
                    begin
                        if (byte_reg == CH_CR)
                        begin
                            if (size_accum_reg == '0)
                            begin
                                phase_next = PH_DONE;
                                res_valid  = 1'b1;
                                res_kind   = KIND_DONE;
                            end
                            else
                            begin
                                phase_next = PH_LF;
                            end
                        end
                        else if (digit.ok && !size_full)
                        begin
                            size_accum_next = size_shifted;
                        end
                        else
                        begin
                            // Extension, stray byte or size overflow
                            phase_next = PH_ERR;
                            res_valid  = 1'b1;
                            res_kind   = KIND_ERR;
                        end
                    end
                    PH_LF:
                    begin
                        if (byte_reg == CH_LF)
                        begin
                            bytes_left_next = size_accum_reg;
                            phase_next      = PH_DATA;
                        end
                        else
                        begin
                            phase_next = PH_ERR;
                            res_valid  = 1'b1;
                            res_kind   = KIND_ERR;
                        end
                    end
                    PH_DATA:
                    begin
                        bytes_left_next = bytes_dec;
                        if (bytes_dec == '0)
                        begin
                            phase_next = PH_TCR;
                        end
                        res_valid = 1'b1;
                        res_kind  = KIND_BYTE;
                        res_byte  = byte_reg;
                    end
                    PH_TCR:
                    begin
                        if (byte_reg == CH_CR)
                        begin
                            phase_next = PH_TLF;
                        end
                        else
                        begin
                            phase_next = PH_ERR;
                            res_valid  = 1'b1;
                            res_kind   = KIND_ERR;
                        end
                    end
                    PH_TLF:
                    begin
                        if (byte_reg == CH_LF)
                        begin
                            size_accum_next = '0;
                            phase_next      = PH_FIRST;
                        end
                        else
                        begin
                            phase_next = PH_ERR;
                            res_valid  = 1'b1;
                            res_kind   = KIND_ERR;
                        end
                    end
                    default:
                    begin
                        // Done or error: drop the byte
                    end
                endcase
            end
            default:
            begin
                // Unused command: drop it
            end
        endcase
    end

    // Input register: payload only needs loading on accept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            cmd_reg  <= cmd;
            byte_reg <= data_byte;
        end
    end

    // Decoder state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FIRST;
            size_accum_reg <= '0;
            bytes_left_reg <= '0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= KIND_BYTE;
            payload_reg    <= 8'd0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && res_valid;
            if (in_valid_reg)
            begin
                phase_reg      <= phase_next;
                size_accum_reg <= size_accum_next;
                bytes_left_reg <= bytes_left_next;
                if (res_valid)
                begin
                    kind_reg    <= res_kind;
                    payload_reg <= res_byte;
                end
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = payload_reg;

`include "http_chunked_body_decoder_top_assert.svh"

    `HCBD_ASSERT_NOW(a_done_phase, out_valid_reg && kind_reg == KIND_DONE, phase_reg == PH_DONE)
    `HCBD_ASSERT_NOW(a_err_phase, out_valid_reg && kind_reg == KIND_ERR, phase_reg == PH_ERR)
    `HCBD_ASSERT_NOW(a_byte_phase, out_valid_reg && kind_reg == KIND_BYTE,
        phase_reg == PH_DATA || phase_reg == PH_TCR)
    `HCBD_ASSERT_NEXT(a_hold_state, out_valid_reg && result_stall, $stable(phase_reg))

endmodule
